/* rtl/core/wbs_pkg.sv */
// Package for the word break segmenter: sizes, dictionary row and port types,
// and the sequencer state type. No dependencies.
package wbs_pkg;

   localparam int MAX_WORD_LEN = 16;
   localparam int DICT_WORDS = 64;

   localparam int IDX_W = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
   localparam int POS_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_TEXT = 1'b1;

   typedef logic [MAX_WORD_LEN-1:0][7:0] byte_row_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic             lane_en;
      logic [POS_W-1:0] lane;
      logic [7:0]       ch;
      logic [LEN_W-1:0] len;
   } dict_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_RESP
   } state_type;

endpackage

/* rtl/core/wbs_dict.sv */
// Dictionary store: one row of characters per entry with a byte write port
// and a registered row read, plus entry lengths with valid bits. Uses wbs_pkg.
module wbs_dict (
   input  logic                     clock,
   input  logic                     reset,
   input  wbs_pkg::dict_wr_type     wr,
   input  logic [wbs_pkg::IDX_W-1:0] rd_addr,
   output wbs_pkg::byte_row_type    rd_row,
   output logic [wbs_pkg::LEN_W-1:0] rd_len
);

   wbs_pkg::byte_row_type           char_mem [wbs_pkg::DICT_WORDS];
   logic [wbs_pkg::LEN_W-1:0]       len_mem [wbs_pkg::DICT_WORDS];
   logic [wbs_pkg::DICT_WORDS-1:0]  len_valid_ff;
   logic [wbs_pkg::DICT_WORDS-1:0]  len_valid_in;
   wbs_pkg::byte_row_type           rd_row_ff;
   logic [wbs_pkg::LEN_W-1:0]       rd_len_ff;

   always_comb begin
      len_valid_in = len_valid_ff;
      if (wr.en) begin
         len_valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= '0;
      end else begin
         len_valid_ff <= len_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.lane_en) begin
         char_mem[wr.addr][wr.lane] <= wr.ch;
      end
      rd_row_ff <= char_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         len_mem[wr.addr] <= wr.len;
      end
      rd_len_ff <= len_valid_ff[rd_addr] ? len_mem[rd_addr] : '0;
   end

   assign rd_row = rd_row_ff;
   assign rd_len = rd_len_ff;

endmodule

/* rtl/core/wbs_match.sv */
// Shared word compare unit: tests one dictionary row against the newest text
// bytes and the reachability bit before the word. Uses wbs_pkg.
module wbs_match (
   input  wbs_pkg::byte_row_type             row,
   input  logic [wbs_pkg::LEN_W-1:0]         len,
   input  wbs_pkg::byte_row_type             recent,
   input  logic [wbs_pkg::MAX_WORD_LEN:0]    reach,
   output logic                              match
);

   logic                      chars_eq;
   logic [wbs_pkg::LEN_W-1:0] sel;
   logic [wbs_pkg::LEN_W-1:0] ridx;

   always_comb begin
      chars_eq = 1'b1;
      sel = '0;
      for (int t = 0; t < wbs_pkg::MAX_WORD_LEN; t++) begin
         sel = wbs_pkg::LEN_W'(32'(len) - 32'd1 - 32'(t));
         if ((t < int'(len)) && (row[t] != recent[sel[wbs_pkg::POS_W-1:0]])) begin
            chars_eq = 1'b0;
         end
      end
      ridx = wbs_pkg::LEN_W'(32'(len) - 32'd1);
      match = (len != '0) && (32'(len) <= wbs_pkg::MAX_WORD_LEN) && reach[ridx] && chars_eq;
   end

endmodule

/* rtl/core/word_break_segmenter.sv */
// Word break segmenter: tests whether a byte stream splits into dictionary words.
// Top level; uses wbs_pkg, wbs_dict and wbs_match.
//
// The req_ channel carries two kinds of transaction. A write transaction
// (req_action 0) stores one character of one dictionary entry and sets its
// length; it gives no response. A text transaction
// (req_action 1) feeds one byte and gives exactly one rsp_ transaction with
// rsp_prefix_breakable and rsp_is_last. req_first_of_text restarts the history.
// A text byte scans every dictionary entry in turn, one entry per cycle through
// the dictionary row read port and the shared compare unit: the sequencer steps
// through ST_SCAN over all entries, ST_LAST to finish the last compare and ST_RESP
// to load the response, and it takes no new byte until that response is loaded.
// req_ready is high only while the block is idle. The response sits in an
// output register; a stalled receiver holds it, and the block still accepts
// the next transaction, but a finished scan waits until that register is free.
// Reset empties the dictionary (all lengths zero) and leaves only the empty
// prefix reachable; no clearing pass is needed.
module word_break_segmenter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic       req_first_of_text,
   input  logic       req_end_of_text,
   input  logic [7:0] req_char_value,
   input  logic [5:0] req_entry_index,
   input  logic [3:0] req_char_pos,
   input  logic [4:0] req_word_len,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_prefix_breakable,
   output logic       rsp_is_last
);

   wbs_pkg::state_type              state_ff;
   wbs_pkg::state_type              state_in;
   logic [wbs_pkg::IDX_W-1:0]       rd_addr_ff;
   logic [wbs_pkg::IDX_W-1:0]       rd_addr_in;
   logic                            cmp_valid_ff;
   logic                            hit_ff;
   logic                            hit_in;
   wbs_pkg::byte_row_type           recent_ff;
   wbs_pkg::byte_row_type           recent_in;
   logic [wbs_pkg::MAX_WORD_LEN:0]  reach_ff;
   logic [wbs_pkg::MAX_WORD_LEN:0]  reach_in;
   logic                            last_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            rsp_break_ff;
   logic                            rsp_last_ff;

   logic                            req_fire;
   logic                            text_fire;
   logic                            scan_end;
   logic                            rsp_load;
   wbs_pkg::dict_wr_type            dict_wr;
   wbs_pkg::byte_row_type           rd_row;
   logic [wbs_pkg::LEN_W-1:0]       rd_len;
   logic                            match;

   assign req_fire = req_valid && req_ready;
   assign text_fire = req_fire && (req_action == wbs_pkg::ACT_TEXT);
   assign scan_end = (rd_addr_ff == wbs_pkg::IDX_W'(wbs_pkg::DICT_WORDS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wbs_pkg::ST_IDLE: begin
            if (text_fire) state_in = wbs_pkg::ST_SCAN;
         end
         wbs_pkg::ST_SCAN: begin
            if (scan_end) state_in = wbs_pkg::ST_LAST;
         end
         wbs_pkg::ST_LAST: begin
            state_in = wbs_pkg::ST_RESP;
         end
         wbs_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = wbs_pkg::ST_IDLE;
         end
         default: begin
            state_in = wbs_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rsp_load = 1'b0;
      rd_addr_in = rd_addr_ff;
      case (state_ff)
         wbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr_in = '0;
         end
         wbs_pkg::ST_SCAN: begin
            if (!scan_end) rd_addr_in = rd_addr_ff + wbs_pkg::IDX_W'(1);
         end
         wbs_pkg::ST_LAST: begin
            rd_addr_in = rd_addr_ff;
         end
         wbs_pkg::ST_RESP: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            rd_addr_in = '0;
         end
      endcase
   end

   always_comb begin
      dict_wr.en = req_fire && (req_action == wbs_pkg::ACT_WRITE) &&
                   (32'(req_entry_index) < wbs_pkg::DICT_WORDS);
      dict_wr.addr = wbs_pkg::IDX_W'(req_entry_index);
      dict_wr.lane_en = (32'(req_char_pos) < wbs_pkg::MAX_WORD_LEN);
      dict_wr.lane = wbs_pkg::POS_W'(req_char_pos);
      dict_wr.ch = req_char_value;
      dict_wr.len = (32'(req_word_len) > wbs_pkg::MAX_WORD_LEN) ?
                    wbs_pkg::LEN_W'(wbs_pkg::MAX_WORD_LEN) : wbs_pkg::LEN_W'(req_word_len);
   end

   always_comb begin
      recent_in = recent_ff;
      reach_in = reach_ff;
      hit_in = hit_ff;
      if (text_fire) begin
         hit_in = 1'b0;
         if (req_first_of_text) begin
            recent_in = '0;
            reach_in = (wbs_pkg::MAX_WORD_LEN + 1)'(1);
         end else begin
            for (int k = wbs_pkg::MAX_WORD_LEN - 1; k > 0; k--) begin
               recent_in[k] = recent_ff[k-1];
            end
         end
         recent_in[0] = req_char_value;
      end else if (cmp_valid_ff) begin
         hit_in = hit_ff | match;
      end else if (rsp_load) begin
         reach_in = {reach_ff[wbs_pkg::MAX_WORD_LEN-1:0], hit_ff};
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wbs_pkg::ST_IDLE;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reach_ff <= (wbs_pkg::MAX_WORD_LEN + 1)'(1);
         recent_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmp_valid_ff <= (state_ff == wbs_pkg::ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         reach_ff <= reach_in;
         recent_ff <= recent_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      if (text_fire) begin
         last_ff <= req_end_of_text;
      end
      if (rsp_load) begin
         rsp_break_ff <= hit_ff;
         rsp_last_ff <= last_ff;
      end
   end

   wbs_dict u_dict (
      .clock   (clock),
      .reset   (reset),
      .wr      (dict_wr),
      .rd_addr (rd_addr_ff),
      .rd_row  (rd_row),
      .rd_len  (rd_len)
   );

   wbs_match u_match (
      .row    (rd_row),
      .len    (rd_len),
      .recent (recent_ff),
      .reach  (reach_ff),
      .match  (match)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prefix_breakable = rsp_break_ff;
   assign rsp_is_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_text_busy: assert property (@(posedge clock) disable iff (reset)
      text_fire |=> !req_ready)
      else $error("block still ready after a text transaction");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == wbs_pkg::ST_SCAN || state_ff == wbs_pkg::ST_LAST))
      else $error("compare outside of scan");

   a_last_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wbs_pkg::ST_LAST) |-> scan_end && cmp_valid_ff)
      else $error("scan ended before the last entry");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == wbs_pkg::ST_IDLE))
      else $error("response not loaded at end of scan");
`endif

endmodule

/* sim/word_break_segmenter_tb.sv */
`timescale 1ns / 100ps
// Testbench for word_break_segmenter: builds dictionaries, streams text made of them,
// and checks every rsp_ transaction against a scoreboard that predicts word breaks.
// Depends on wbs_pkg and the word_break_segmenter RTL.
module word_break_segmenter_tb;

   localparam int ITEM_TARGET = 750;
   localparam int LONG_HOLD = 500;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 125;

   typedef struct {
      logic                      action;
      logic                      first_of_text;
      logic                      end_of_text;
      logic [7:0]                char_value;
      logic [wbs_pkg::IDX_W-1:0] entry_index;
      logic [wbs_pkg::POS_W-1:0] char_pos;
      logic [wbs_pkg::LEN_W-1:0] word_len;
   } seg_req_type;

   typedef struct {
      logic breakable;
      logic last;
   } seg_rsp_type;

   class breakability_scoreboard_type;
      logic [7:0]                            word_bytes [wbs_pkg::DICT_WORDS][wbs_pkg::MAX_WORD_LEN];
      int                                    word_length [wbs_pkg::DICT_WORDS];
      logic [wbs_pkg::MAX_WORD_LEN-1:0][7:0] history;
      logic [wbs_pkg::MAX_WORD_LEN:0]        reachable;
      seg_rsp_type                           breakable_expected [$];
      int                                    mismatches;
      int                                    results_seen;

      function new();
         foreach (word_bytes[e, t]) word_bytes[e][t] = 8'h00;
         foreach (word_length[e]) word_length[e] = 0;
         history = '0;
         reachable = (wbs_pkg::MAX_WORD_LEN + 1)'(1);
         mismatches = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return breakable_expected.size();
      endfunction

      function void note_request(seg_req_type r);
         bit          hit;
         bit          fits;
         int          n;
         seg_rsp_type exp_rsp;
         if (r.action == wbs_pkg::ACT_WRITE) begin
            if (r.entry_index < wbs_pkg::DICT_WORDS) begin
               if (r.char_pos < wbs_pkg::MAX_WORD_LEN) begin
                  word_bytes[r.entry_index][r.char_pos] = r.char_value;
               end
               word_length[r.entry_index] = (r.word_len > wbs_pkg::MAX_WORD_LEN) ?
                                            wbs_pkg::MAX_WORD_LEN : r.word_len;
            end
            return;
         end
         if (r.first_of_text) begin
            history = '0;
            reachable = (wbs_pkg::MAX_WORD_LEN + 1)'(1);
         end
         history = {history[wbs_pkg::MAX_WORD_LEN-2:0], r.char_value};
         hit = 1'b0;
         for (int e = 0; e < wbs_pkg::DICT_WORDS && !hit; e++) begin
            n = word_length[e];
            if (n != 0 && reachable[n-1]) begin
               fits = 1'b1;
               for (int t = 0; t < n; t++) begin
                  if (word_bytes[e][t] != history[n-1-t]) fits = 1'b0;
               end
               hit = fits;
            end
         end
         reachable = {reachable[wbs_pkg::MAX_WORD_LEN-1:0], hit};
         exp_rsp.breakable = hit;
         exp_rsp.last = r.end_of_text;
         breakable_expected.push_back(exp_rsp);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] response %0d: %s", $time, results_seen, what);
      endtask

      task check_result(logic breakable, logic last);
         seg_rsp_type want;
         results_seen++;
         if (breakable_expected.size() == 0) begin
            report_mismatch("response with no text transaction pending");
            return;
         end
         want = breakable_expected.pop_front();
         if (breakable !== want.breakable) begin
            report_mismatch($sformatf("prefix_breakable %b, expected %b", breakable,
                                      want.breakable));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("is_last %b, expected %b", last, want.last));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = wbs_pkg::ACT_WRITE;
   logic       req_first_of_text = 1'b0;
   logic       req_end_of_text = 1'b0;
   logic [7:0] req_char_value = 8'h00;
   logic [5:0] req_entry_index = 6'd0;
   logic [3:0] req_char_pos = 4'd0;
   logic [4:0] req_word_len = 5'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_prefix_breakable;
   logic       rsp_is_last;

   breakability_scoreboard_type sb = new();
   bit          char_written [wbs_pkg::DICT_WORDS][wbs_pkg::MAX_WORD_LEN];
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;
   bit          long_hold_request = 1'b0;
   int          items_sent = 0;
   int unsigned cycle_count;

   word_break_segmenter i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_first_of_text    (req_first_of_text),
      .req_end_of_text      (req_end_of_text),
      .req_char_value       (req_char_value),
      .req_entry_index      (req_entry_index),
      .req_char_pos         (req_char_pos),
      .req_word_len         (req_word_len),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_prefix_breakable (rsp_prefix_breakable),
      .rsp_is_last          (rsp_is_last)
   );

   always #10 clock = ~clock;

   task automatic send_item(seg_req_type r);
      int gap;
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= r.action;
      req_first_of_text <= r.first_of_text;
      req_end_of_text <= r.end_of_text;
      req_char_value <= r.char_value;
      req_entry_index <= r.entry_index;
      req_char_pos <= r.char_pos;
      req_word_len <= r.word_len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      items_sent++;
   endtask

   task automatic send_write(int entry, int pos, logic [7:0] ch, int len);
      seg_req_type r;
      r.action = wbs_pkg::ACT_WRITE;
      r.first_of_text = 1'($urandom_range(0, 1));
      r.end_of_text = 1'($urandom_range(0, 1));
      r.char_value = ch;
      r.entry_index = wbs_pkg::IDX_W'(entry);
      r.char_pos = wbs_pkg::POS_W'(pos);
      r.word_len = wbs_pkg::LEN_W'(len);
      char_written[entry][pos] = 1'b1;
      send_item(r);
   endtask

   task automatic send_byte(logic [7:0] ch, bit first, bit last);
      seg_req_type r;
      r.action = wbs_pkg::ACT_TEXT;
      r.first_of_text = first;
      r.end_of_text = last;
      r.char_value = ch;
      r.entry_index = wbs_pkg::IDX_W'($urandom_range(0, wbs_pkg::DICT_WORDS - 1));
      r.char_pos = wbs_pkg::POS_W'($urandom_range(0, wbs_pkg::MAX_WORD_LEN - 1));
      r.word_len = wbs_pkg::LEN_W'($urandom_range(0, 31));
      send_item(r);
   endtask

   function automatic logic [7:0] word_char(bit wide);
      return wide ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 2));
   endfunction

   // Write positions in order; only the last write makes the entry live.
   task automatic store_word(int entry, int n);
      bit wide;
      int len;
      wide = ($urandom_range(0, 3) == 0);
      for (int p = 0; p < n; p++) begin
         len = 0;
         if (p == n - 1) begin
            len = (n == wbs_pkg::MAX_WORD_LEN && $urandom_range(0, 1)) ?
                  $urandom_range(wbs_pkg::MAX_WORD_LEN, 31) : n;
         end
         send_write(entry, p, word_char(wide), len);
      end
   endtask

   // Random write; length never reaches past the written prefix of the entry.
   task automatic scramble_entry();
      int entry;
      int pos;
      int filled;
      int len;
      entry = $urandom_range(0, wbs_pkg::DICT_WORDS - 1);
      pos = $urandom_range(0, wbs_pkg::MAX_WORD_LEN - 1);
      char_written[entry][pos] = 1'b1;
      filled = 0;
      while (filled < wbs_pkg::MAX_WORD_LEN && char_written[entry][filled]) filled++;
      len = 0;
      if (filled > 0 && $urandom_range(0, 1)) len = $urandom_range(1, filled);
      if (filled == wbs_pkg::MAX_WORD_LEN && $urandom_range(0, 1)) begin
         len = $urandom_range(wbs_pkg::MAX_WORD_LEN, 31);
      end
      send_write(entry, pos, word_char(1'b1), len);
   endtask

   task automatic send_text();
      logic [7:0] bytes_q [$];
      int         used [$];
      int         e;
      bit         first;
      bit         last;
      for (int i = 0; i < wbs_pkg::DICT_WORDS; i++) begin
         if (sb.word_length[i] != 0) used.push_back(i);
      end
      repeat ($urandom_range(1, 5)) begin
         if (used.size() > 0 && $urandom_range(0, 99) < 85) begin
            e = used[$urandom_range(0, used.size() - 1)];
            for (int t = 0; t < sb.word_length[e]; t++) bytes_q.push_back(sb.word_bytes[e][t]);
         end else begin
            repeat ($urandom_range(1, 2)) bytes_q.push_back(word_char(1'($urandom_range(0, 1))));
         end
      end
      foreach (bytes_q[i]) begin
         first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
         last = (i == bytes_q.size() - 1) ? ($urandom_range(0, 9) != 0)
                                          : ($urandom_range(0, 39) == 0);
         send_byte(bytes_q[i], first, last);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_prefix_breakable, rsp_is_last);
            stall_left = receiver_idles ? $urandom_range(0, 4) : 0;
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) hold_left--;
         rsp_ready <= (stall_left == 0 && hold_left == 0);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int  phase;
      int  pick;
      int  n;
      bit  held;
      bit  drained;
      held = 1'b0;
      drained = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty dictionary, then a full-length word with an oversized length
      send_byte(8'hff, 1'b1, 1'b0);
      for (int p = 0; p < wbs_pkg::MAX_WORD_LEN; p++) begin
         send_write(wbs_pkg::DICT_WORDS - 1, p, 8'hff,
                    (p == wbs_pkg::MAX_WORD_LEN - 1) ? 31 : 0);
      end
      send_write(0, 0, 8'h00, 1);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'h01, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         phase = items_sent / PHASE_ITEMS;
         sender_idles = (phase != 1 && phase != 3);
         receiver_idles = (phase != 2 && phase != 3);
         if (!held && items_sent >= 250) begin
            held = 1'b1;
            long_hold_request = 1'b1;
         end
         if (!drained && items_sent >= 500) begin
            drained = 1'b1;
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            if ($urandom_range(0, 29) == 0) n = wbs_pkg::MAX_WORD_LEN;
            else if ($urandom_range(0, 9) == 0) n = $urandom_range(5, wbs_pkg::MAX_WORD_LEN);
            else n = $urandom_range(1, 4);
            store_word($urandom_range(0, wbs_pkg::DICT_WORDS - 1), n);
         end else if (pick < 27) begin
            scramble_entry();
         end else begin
            send_text();
         end
      end

      receiver_idles = 1'b0;
      wait_drained();
      repeat (wbs_pkg::DICT_WORDS + 8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
